>>> hw/rtl/triplet_sum_sort_two_pointer_core_defines.svh
// Assertion macros shared by the triplet-sum search RTL.
// Stands alone; included by the files that carry concurrent assertions.
`ifndef TRIPLET_SUM_SORT_TWO_POINTER_CORE_DEFINES_SVH
`define TRIPLET_SUM_SORT_TWO_POINTER_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define TSSP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked while reset is high.
`define TSSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/tssp_pkg.sv
// Shared types and constants for the triplet-sum search core.
// No dependencies; compiled before all other RTL files.
package tssp_pkg;

  localparam int TARGET_WIDTH = 18;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SO_RD,
    ST_SO_KEY,
    ST_SO_CMP,
    ST_SO_PUT,
    ST_SR_ANCH,
    ST_SR_WANT,
    ST_SR_CMP,
    ST_DONE
  } state_t;

endpackage

>>> hw/rtl/tssp_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module tssp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  output logic [WIDTH-1:0]         rdata0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

>>> hw/rtl/triplet_sum_sort_two_pointer_core.sv
// Triplet-sum search core: loads a set, sorts it, runs a two-pointer search.
// Depends on tssp_pkg, tssp_ram and triplet_sum_sort_two_pointer_core_defines.svh.
//
// Usage:
//   The input channel (in_valid/in_ready, value, last) takes one word per
//   element. Each word is taken while the core is idle. A word
//   with last set closes the set; the core then sorts the stored elements and
//   searches them, and in_ready stays low until the result is handed to the
//   output register. One result word (found, overflow) leaves on the output
//   channel (out_valid/out_ready) for every set.
//   Words beyond MAX_ITEMS are dropped, a closing word included, and the
//   result then reports overflow. Sets of fewer than three elements report
//   found low; they skip the sort and the search and go straight to ST_DONE.
//   After the closing word of an n-element set, an insertion sort puts the
//   elements in order, and a two-pointer search then runs from each anchor
//   in turn until a match is found or the anchors run out.
//   Every step goes through the single element RAM with its registered reads.
//   If the receiver stalls, the result waits in the output register while the
//   next set loads; a finished search holds until that register is free.
//   cfg_we writes cfg_data into target_sum. Reset clears the element count,
//   the overflow flag, target_sum and the output valid.
`include "triplet_sum_sort_two_pointer_core_defines.svh"

module triplet_sum_sort_two_pointer_core #(
  parameter int MAX_ITEMS   = 64,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [VALUE_WIDTH-1:0]           value,
  input  logic                                    last,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    found,
  output logic                                    overflow,
  input  logic                                    cfg_we,
  input  logic signed [tssp_pkg::TARGET_WIDTH-1:0] cfg_data
);
  import tssp_pkg::*;

  localparam int AW   = $clog2(MAX_ITEMS);
  localparam int CNTW = $clog2(MAX_ITEMS + 1);
  localparam int VW   = VALUE_WIDTH;
  localparam int CW   = ((TARGET_WIDTH > VW) ? TARGET_WIDTH : VW) + 2;

  state_t state, state_next;

  logic [CNTW-1:0] count, count_next;
  logic [CNTW-1:0] n_items, n_items_next;
  logic            ovf_seen, ovf_seen_next;
  logic [AW-1:0]   a, a_next;
  logic [AW-1:0]   b, b_next;
  logic [AW-1:0]   i, i_next;
  logic [AW-1:0]   lo, lo_next;
  logic [AW-1:0]   hi, hi_next;
  logic [VW-1:0]   key, key_next;
  logic signed [CW-1:0] want, want_next;
  logic signed [CW-1:0] sum;
  logic signed [TARGET_WIDTH-1:0] target_sum;
  logic            res_found, res_found_next;
  logic            res_ovf, res_ovf_next;
  logic            out_valid_next, found_next, overflow_next;
  logic [CNTW-1:0] cnt_after;
  logic            full;

  logic            we;
  logic [AW-1:0]   waddr, raddr0, raddr1;
  logic [VW-1:0]   wdata, rd0, rd1;

  tssp_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (raddr0),
    .rdata0 (rd0),
    .raddr1 (raddr1),
    .rdata1 (rd1)
  );

  assign in_ready = (state == ST_IDLE);
  assign full     = (count >= CNTW'(MAX_ITEMS));
  assign cnt_after = full ? count : count + CNTW'(1);
  assign sum = {{(CW-VW){rd0[VW-1]}}, rd0} + {{(CW-VW){rd1[VW-1]}}, rd1};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      ovf_seen   <= 1'b0;
      out_valid  <= 1'b0;
      target_sum <= '0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      ovf_seen  <= ovf_seen_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        target_sum <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_items   <= n_items_next;
    a         <= a_next;
    b         <= b_next;
    i         <= i_next;
    lo        <= lo_next;
    hi        <= hi_next;
    key       <= key_next;
    want      <= want_next;
    res_found <= res_found_next;
    res_ovf   <= res_ovf_next;
    found     <= found_next;
    overflow  <= overflow_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    ovf_seen_next  = ovf_seen;
    n_items_next   = n_items;
    a_next         = a;
    b_next         = b;
    i_next         = i;
    lo_next        = lo;
    hi_next        = hi;
    key_next       = key;
    want_next      = want;
    res_found_next = res_found;
    res_ovf_next   = res_ovf;
    out_valid_next = out_valid && !out_ready;
    found_next     = found;
    overflow_next  = overflow;
    we             = 1'b0;
    waddr          = count[AW-1:0];
    wdata          = value;
    raddr0         = a;
    raddr1         = hi;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (!full) begin
            we         = 1'b1;
            count_next = cnt_after;
          end else begin
            ovf_seen_next = 1'b1;
          end
          if (last) begin
            n_items_next   = cnt_after;
            count_next     = '0;
            ovf_seen_next  = 1'b0;
            res_ovf_next   = ovf_seen || full;
            res_found_next = 1'b0;
            a_next         = AW'(1);
            if (cnt_after >= CNTW'(3)) begin
              state_next = ST_SO_RD;
            end else begin
              state_next = ST_DONE;
            end
          end
        end
      end

      ST_SO_RD: begin
        raddr0     = a;
        state_next = ST_SO_KEY;
      end

      ST_SO_KEY: begin
        key_next   = rd0;
        b_next     = a;
        raddr0     = a - AW'(1);
        state_next = ST_SO_CMP;
      end

      ST_SO_CMP: begin
        // rd0 holds the element just below slot b; shift it up while it is larger.
        if ($signed(rd0) > $signed(key)) begin
          we     = 1'b1;
          waddr  = b;
          wdata  = rd0;
          b_next = b - AW'(1);
          if (b == AW'(1)) begin
            state_next = ST_SO_PUT;
          end else begin
            raddr0 = b - AW'(2);
          end
        end else begin
          state_next = ST_SO_PUT;
        end
      end

      ST_SO_PUT: begin
        we    = 1'b1;
        waddr = b;
        wdata = key;
        if (CNTW'(a) + CNTW'(1) == n_items) begin
          i_next     = '0;
          state_next = ST_SR_ANCH;
        end else begin
          a_next     = a + AW'(1);
          state_next = ST_SO_RD;
        end
      end

      ST_SR_ANCH: begin
        raddr0     = i;
        state_next = ST_SR_WANT;
      end

      ST_SR_WANT: begin
        want_next = {{(CW-TARGET_WIDTH){target_sum[TARGET_WIDTH-1]}}, target_sum}
                    - {{(CW-VW){rd0[VW-1]}}, rd0};
        lo_next    = i + AW'(1);
        hi_next    = AW'(n_items - CNTW'(1));
        raddr0     = lo_next;
        raddr1     = hi_next;
        state_next = ST_SR_CMP;
      end

      ST_SR_CMP: begin
        if (sum == want) begin
          res_found_next = 1'b1;
          state_next     = ST_DONE;
        end else begin
          if (sum < want) begin
            lo_next = lo + AW'(1);
          end else begin
            hi_next = hi - AW'(1);
          end
          raddr0 = lo_next;
          raddr1 = hi_next;
          if (lo_next >= hi_next) begin
            // Pointers met: move to the next anchor if two elements remain above it.
            if (CNTW'(i) + CNTW'(3) < n_items) begin
              i_next     = i + AW'(1);
              state_next = ST_SR_ANCH;
            end else begin
              state_next = ST_DONE;
            end
          end
        end
      end

      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          found_next     = res_found;
          overflow_next  = res_ovf;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `TSSP_ASSERT_IMPL(a_ptr_order, clk, rst, state == ST_SR_CMP, lo < hi, "search pointers crossed")
  `TSSP_ASSERT_IMPL(a_sort_slot, clk, rst, state == ST_SO_CMP, (b != '0) && (b <= a), "sort slot out of range")
  `TSSP_ASSERT_IMPL(a_count_max, clk, rst, 1'b1, count <= CNTW'(MAX_ITEMS), "element count above store size")
  `TSSP_ASSERT_NEXT(a_done_load, clk, rst, (state == ST_DONE) && (!out_valid || out_ready), out_valid, "result not loaded")

endmodule
